/* rtl/cdf_pkg.sv */
// Shared constants, types and the scaled cosine table for the cepstral DCT block.
// Used by every module under rtl; depends on nothing.
package cdf_pkg;

  localparam int MelBins   = 26;
  localparam int MaxCoeffs = 16;
  localparam int OutLimit  = 16;
  localparam int EffCoeffs = (MaxCoeffs < OutLimit) ? MaxCoeffs : OutLimit;

  localparam int EnergyW = 24;
  localparam int CoefW   = 16;
  localparam int ProdW   = EnergyW + CoefW;
  localparam int AccW    = 48;
  localparam int CoeffW  = 32;
  localparam int IdxW    = 4;
  localparam int CfgW    = 5;
  localparam int RndBits = 15;

  localparam logic [CfgW-1:0] CfgReset = CfgW'(12);

  localparam int MW   = $clog2(MelBins);
  localparam int PhW  = $clog2(4 * MelBins);
  localparam int TW   = $clog2(MelBins + 1);
  localparam int CosW = 17;

  localparam logic [63:0] PiQ30 = 64'd3373259426;

  typedef enum logic [1:0] {
    S_LOAD,
    S_CALC,
    S_WAIT
  } seq_state_t;

  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic signed [CoefW-1:0] coef;
  } mac_ctl_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            last;
  } out_tag_t;

  typedef logic [MelBins:0][CosW-1:0] cos_tab_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    logic [63:0] rem;
    r    = '0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r   = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Magnitude of sqrt(2/M)*cos(pi*t/(2M)) in Q1.15 for t in 0..M.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [63:0] scale;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    longint      sum;
    scale = isqrt64((64'd1 << 61) / 64'(MelBins));
    for (int t = 0; t <= MelBins; t++) begin
      x    = (PiQ30 * 64'(t) + 64'(MelBins)) / 64'(2 * MelBins);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(1) << 30;
      for (int i = 1; i <= 12; i++) begin
        term = ((term * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
        if (i[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      prod   = 64'(sum) * scale + (64'd1 << 44);
      tab[t] = CosW'(prod >> 45);
    end
    return tab;
  endfunction

  localparam cos_tab_t CosTab = build_cos_tab();

endpackage

/* rtl/cdf_frame_store.sv */
// Frame buffer holding one frame of mel values, registered read port.
// Depends on cdf_pkg.
module cdf_frame_store
  import cdf_pkg::*;
(
  input  logic                      clk,
  input  logic                      we,
  input  logic [MW-1:0]             waddr,
  input  logic signed [EnergyW-1:0] wdata,
  input  logic                      re,
  input  logic [MW-1:0]             raddr,
  output logic signed [EnergyW-1:0] rdata
);

  logic signed [EnergyW-1:0] mem [MelBins];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/cdf_mac.sv */
// Shared multiply-accumulate unit with rounding to Q15.16 and saturation.
// Depends on cdf_pkg; driven by cdf_ctrl and cdf_frame_store.
module cdf_mac
  import cdf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  mac_ctl_t                  ctl,
  input  logic signed [EnergyW-1:0] energy,
  input  logic                      res_take,
  output logic                      res_valid,
  output logic signed [CoeffW-1:0]  res
);

  localparam logic [AccW-1:0] RndHalf = AccW'(1) << (RndBits - 1);
  localparam int              QW      = AccW - RndBits;

  logic                    v1;
  logic                    first1;
  logic                    last1;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc;
  logic                    fin;

  logic [AccW-1:0]         rsum;
  logic [QW-1:0]           q;
  logic signed [CoeffW-1:0] res_next;

  always_comb begin
    rsum = acc + RndHalf;
    q    = rsum[AccW-1:RndBits];
    if (q[QW-1] != q[CoeffW-1]) begin
      res_next = q[QW-1] ? {1'b1, {(CoeffW-1){1'b0}}} : {1'b0, {(CoeffW-1){1'b1}}};
    end else begin
      res_next = q[CoeffW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod   <= energy * ctl.coef;
    first1 <= ctl.first;
    last1  <= ctl.last;
    if (v1) begin
      acc <= first1 ? AccW'(prod) : acc + AccW'(prod);
    end
    if (fin) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      fin       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1  <= ctl.valid;
      fin <= v1 && last1;
      if (fin) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) fin |-> !res_valid)
    else $error("cdf_mac: new sum finished while previous result pending");
`endif

endmodule

/* rtl/cdf_ctrl.sv */
// Sequencer: frame loading, coefficient loop, cosine phase walk and table lookup.
// Depends on cdf_pkg; feeds cdf_frame_store and cdf_mac.
module cdf_ctrl
  import cdf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_wr_en,
  input  logic [CfgW-1:0] cfg_wr_data,
  output logic            st_we,
  output logic [MW-1:0]   st_waddr,
  output logic            st_re,
  output logic [MW-1:0]   st_raddr,
  output mac_ctl_t        mac_ctl,
  input  logic            res_take,
  output out_tag_t        out_tag
);

  localparam logic [MW-1:0]  BinLast = MW'(MelBins - 1);
  localparam logic [PhW:0]   Ph4M    = (PhW + 1)'(4 * MelBins);
  localparam logic [PhW:0]   Ph2M    = (PhW + 1)'(2 * MelBins);
  localparam logic [PhW:0]   Ph1M    = (PhW + 1)'(MelBins);
  localparam logic signed [CosW:0] CoefMax = (CosW + 1)'((1 << (CoefW - 1)) - 1);

  seq_state_t      state;
  seq_state_t      state_next;
  logic [MW-1:0]   load_cnt;
  logic [MW-1:0]   m_cnt;
  logic [IdxW-1:0] k_cnt;
  logic [IdxW-1:0] k_last;
  logic [PhW-1:0]  phase;
  logic [PhW-1:0]  base;
  logic [PhW-1:0]  step;
  logic [CfgW-1:0] coeff_count;
  mac_ctl_t        mac_ctl_next;

  logic [CfgW-1:0]   n_eff;
  logic [IdxW-1:0]   eff_last;
  logic [PhW:0]      ph_sum;
  logic [PhW:0]      base_sum;
  logic [PhW:0]      step_sum;
  logic [PhW-1:0]    phase_adv;
  logic [PhW-1:0]    base_adv;
  logic [PhW-1:0]    step_adv;
  logic [PhW:0]      t1;
  logic [PhW:0]      t2;
  logic              neg;
  logic [CosW-1:0]   mag;
  logic signed [CosW:0] coef_wide;

  always_comb begin
    priority if (coeff_count == '0) begin
      n_eff = CfgW'(1);
    end else if (coeff_count > CfgW'(EffCoeffs)) begin
      n_eff = CfgW'(EffCoeffs);
    end else begin
      n_eff = coeff_count;
    end
    eff_last = IdxW'(n_eff - CfgW'(1));
  end

  always_comb begin
    ph_sum    = {1'b0, phase} + {1'b0, step};
    phase_adv = (ph_sum >= Ph4M) ? PhW'(ph_sum - Ph4M) : PhW'(ph_sum);
    base_sum  = {1'b0, base} + (PhW + 1)'(1);
    base_adv  = (base_sum >= Ph4M) ? PhW'(base_sum - Ph4M) : PhW'(base_sum);
    step_sum  = {1'b0, step} + (PhW + 1)'(2);
    step_adv  = (step_sum >= Ph4M) ? PhW'(step_sum - Ph4M) : PhW'(step_sum);
  end

  // Fold the angle into the first quadrant, look up the scaled cosine and apply its sign.
  always_comb begin
    t1        = ({1'b0, phase} > Ph2M) ? Ph4M - {1'b0, phase} : {1'b0, phase};
    neg       = t1 > Ph1M;
    t2        = neg ? Ph2M - t1 : t1;
    mag       = CosTab[t2[TW-1:0]];
    coef_wide = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (coef_wide > CoefMax) begin
      coef_wide = CoefMax;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid && load_cnt == BinLast) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (m_cnt == BinLast) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (res_take) begin
          state_next = (k_cnt == k_last) ? S_LOAD : S_CALC;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready           = 1'b0;
    st_re              = 1'b0;
    mac_ctl_next       = '0;
    mac_ctl_next.first = m_cnt == '0;
    mac_ctl_next.last  = m_cnt == BinLast;
    mac_ctl_next.coef  = CoefW'(coef_wide);
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
      end
      S_CALC: begin
        st_re              = 1'b1;
        mac_ctl_next.valid = 1'b1;
      end
      S_WAIT: begin
      end
      default: begin
      end
    endcase
    st_we    = in_ready && in_valid;
    st_waddr = load_cnt;
    st_raddr = m_cnt;
  end

  assign out_tag.index = k_cnt;
  assign out_tag.last  = k_cnt == k_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      load_cnt    <= '0;
      m_cnt       <= '0;
      k_cnt       <= '0;
      k_last      <= '0;
      phase       <= '0;
      base        <= '0;
      step        <= '0;
      coeff_count <= CfgReset;
      mac_ctl     <= '0;
    end else begin
      state   <= state_next;
      mac_ctl <= mac_ctl_next;
      if (cfg_wr_en) begin
        coeff_count <= cfg_wr_data;
      end
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (load_cnt == BinLast) begin
              load_cnt <= '0;
              m_cnt    <= '0;
              k_cnt    <= '0;
              k_last   <= eff_last;
              base     <= PhW'(1);
              step     <= PhW'(2);
              phase    <= PhW'(1);
            end else begin
              load_cnt <= load_cnt + MW'(1);
            end
          end
        end
        S_CALC: begin
          phase <= phase_adv;
          m_cnt <= (m_cnt == BinLast) ? '0 : m_cnt + MW'(1);
        end
        S_WAIT: begin
          if (res_take && k_cnt != k_last) begin
            k_cnt <= k_cnt + IdxW'(1);
            base  <= base_adv;
            step  <= step_adv;
            phase <= base_adv;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_bound: assert property (@(posedge clk) disable iff (rst) load_cnt <= BinLast)
    else $error("cdf_ctrl: load count out of range");
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && load_cnt == BinLast) |=> !in_ready)
    else $error("cdf_ctrl: still ready after frame completed");
  a_take_wait: assert property (@(posedge clk) disable iff (rst)
    res_take |-> (state == S_WAIT))
    else $error("cdf_ctrl: result taken outside wait state");
`endif

endmodule

/* rtl/cepstral_dct_frame_top.sv */
// Top level of the cepstral DCT block: sequencer, frame buffer, MAC and output register.
// Depends on cdf_pkg, cdf_ctrl, cdf_frame_store and cdf_mac.
//
//   channel   signals                                                          dir
//   input     in_valid, in_ready, bin_energy                                   in
//   output    out_valid, out_ready, cepstral_coeff, coeff_index, frame_last    out
//   config    cfg_wr_en, cfg_wr_data                                           in
//
// Loading takes one mel value per valid cycle; in_ready is high only while loading.
// Each coefficient sums all MelBins products on the single shared multiplier, then
// passes through the MAC pipeline and the handoff to the output register.
// Reset clears the sequencer and sets coeff_count to 12; the frame buffer is not cleared.
// A stalled output holds in its register and the sequencer waits before the next sum.
module cepstral_dct_frame_top
  import cdf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [EnergyW-1:0] bin_energy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [CoeffW-1:0]  cepstral_coeff,
  output logic [IdxW-1:0]           coeff_index,
  output logic                      frame_last,
  input  logic                      cfg_wr_en,
  input  logic [CfgW-1:0]           cfg_wr_data
);

  logic                      st_we;
  logic [MW-1:0]             st_waddr;
  logic                      st_re;
  logic [MW-1:0]             st_raddr;
  logic signed [EnergyW-1:0] st_rdata;
  mac_ctl_t                  mac_ctl;
  out_tag_t                  out_tag;
  logic                      res_valid;
  logic signed [CoeffW-1:0]  res;
  logic                      res_take;

  assign res_take = res_valid && (!out_valid || out_ready);

  cdf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .st_we       (st_we),
    .st_waddr    (st_waddr),
    .st_re       (st_re),
    .st_raddr    (st_raddr),
    .mac_ctl     (mac_ctl),
    .res_take    (res_take),
    .out_tag     (out_tag)
  );

  cdf_frame_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (bin_energy),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  cdf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .energy    (st_rdata),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (res_take) begin
      cepstral_coeff <= res;
      coeff_index    <= out_tag.index;
      frame_last     <= out_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
